>>> rtl/redc_pkg.sv
// Shared constants, codes, queue control types and the cell-count helper
// for the Redcode battle executor. No dependencies.
package redc_pkg;

   localparam int CORE_SIZE   = 1024;
   localparam int CORE_AW     = $clog2(CORE_SIZE);
   localparam int FIELD_W     = 10;
   localparam int WORD_W      = 32;
   localparam int QUEUE_DEPTH = 64;
   localparam int Q_AW        = $clog2(QUEUE_DEPTH);
   localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W     = CORE_AW + 1;
   localparam int CELL_W      = $clog2(CORE_SIZE + 1);

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TURN  = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] RES_RUNNING = 2'd0;
   localparam logic [1:0] RES_FIRST   = 2'd1;
   localparam logic [1:0] RES_SECOND  = 2'd2;
   localparam logic [1:0] RES_TIE     = 2'd3;

   localparam logic [3:0] OP_DAT = 4'd0;
   localparam logic [3:0] OP_MOV = 4'd1;
   localparam logic [3:0] OP_ADD = 4'd2;
   localparam logic [3:0] OP_SUB = 4'd3;
   localparam logic [3:0] OP_JMP = 4'd4;
   localparam logic [3:0] OP_JMZ = 4'd5;
   localparam logic [3:0] OP_JMN = 4'd6;
   localparam logic [3:0] OP_DJN = 4'd7;
   localparam logic [3:0] OP_CMP = 4'd8;
   localparam logic [3:0] OP_SPL = 4'd9;

   localparam logic [1:0] MODE_IMM = 2'd0;
   localparam logic [1:0] MODE_REL = 2'd1;
   localparam logic [1:0] MODE_IND = 2'd2;

   localparam logic [1:0] OWNER_FIRST  = 2'd1;
   localparam logic [1:0] OWNER_SECOND = 2'd2;

   typedef struct packed {
      logic               pop;
      logic               push;
      logic               init;
      logic               refresh;
      logic [ENTRY_W-1:0] wdata;
   } redc_qctl_type;

   typedef struct packed {
      logic [Q_CW-1:0]    count;
      logic [ENTRY_W-1:0] front;
      logic               full;
   } redc_qstat_type;

   function automatic logic [CELL_W-1:0] cell_count_next(
      input logic [CELL_W-1:0] cnt,
      input logic [1:0]        old_owner,
      input logic [1:0]        new_owner,
      input logic [1:0]        tag);
      logic [CELL_W-1:0] r;
      r = cnt;
      if (old_owner == tag) r = r - 1'b1;
      if (new_owner == tag) r = r + 1'b1;
      return r;
   endfunction

endpackage

>>> rtl/redc_alu.sv
// Shared 10-bit add/subtract unit used for all address offsets and field
// arithmetic. Depends on redc_pkg.
module redc_alu import redc_pkg::*; (
   input  logic [FIELD_W-1:0] a,
   input  logic [FIELD_W-1:0] b,
   input  logic               sub,
   output logic [FIELD_W-1:0] sum
);
   assign sum = sub ? (a - b) : (a + b);
endmodule

>>> rtl/redc_core.sv
// Core memory: one write port and one registered read port.
// Depends on redc_pkg.
module redc_core import redc_pkg::*; (
   input  logic               clock,
   input  logic               we,
   input  logic [CORE_AW-1:0] waddr,
   input  logic [WORD_W-1:0]  wdata,
   input  logic               ren,
   input  logic [CORE_AW-1:0] raddr,
   output logic [WORD_W-1:0]  rdata
);
   logic [WORD_W-1:0] mem [CORE_SIZE];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (ren) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/redc_queue.sv
// Process queue of one player: entry memory, head, fill count and a
// registered copy of the front entry. Depends on redc_pkg.
module redc_queue import redc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  redc_qctl_type  ctl,
   output redc_qstat_type stat
);
   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [Q_AW-1:0]    head_ff, head_in, tail;
   logic [Q_CW-1:0]    count_ff, count_in;
   logic [ENTRY_W-1:0] front_ff;
   logic [Q_AW:0]      tail_sum;
   logic               full;

   assign full     = (count_ff == Q_CW'(QUEUE_DEPTH));
   assign tail_sum = {1'b0, head_ff} + count_ff[Q_AW:0];
   assign tail     = (tail_sum >= (Q_AW+1)'(QUEUE_DEPTH)) ?
                     Q_AW'(tail_sum - (Q_AW+1)'(QUEUE_DEPTH)) : tail_sum[Q_AW-1:0];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.init) begin
         head_in  = '0;
         count_in = Q_CW'(1);
      end else if (ctl.pop) begin
         head_in  = (head_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctl.push && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         mem[0]   <= ctl.wdata;
         front_ff <= ctl.wdata;
      end else if (ctl.push && !full) begin
         mem[tail] <= ctl.wdata;
      end else if (ctl.refresh) begin
         front_ff <= mem[head_ff];
      end
   end

   assign stat.count = count_ff;
   assign stat.front = front_ff;
   assign stat.full  = full;
endmodule

>>> rtl/redc_sequencer.sv
// Command sequencer: clearing pass, load, read, start scan and the turn
// micro-sequence. Depends on redc_pkg, redc_alu, redc_core and redc_queue.
module redc_sequencer import redc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [9:0]        req_address,
   input  logic [31:0]       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_outcome,
   output logic [15:0]       rsp_turn_count,
   output logic [10:0]       rsp_first_cells,
   output logic [10:0]       rsp_second_cells,
   output logic [31:0]       rsp_read_data,
   output logic [9:0]        rsp_first_front_pc,
   output logic [9:0]        rsp_second_front_pc,
   output logic [6:0]        rsp_first_processes,
   output logic [6:0]        rsp_second_processes,
   output logic              rsp_split_overflow,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_LD_WR   = 5'd2;
   localparam logic [4:0] S_RD_DAT  = 5'd3;
   localparam logic [4:0] S_SCAN_RD = 5'd4;
   localparam logic [4:0] S_SCAN_EV = 5'd5;
   localparam logic [4:0] S_START   = 5'd6;
   localparam logic [4:0] S_CHK     = 5'd7;
   localparam logic [4:0] S_RUN     = 5'd8;
   localparam logic [4:0] S_ARES    = 5'd9;
   localparam logic [4:0] S_AIND    = 5'd10;
   localparam logic [4:0] S_BRES    = 5'd11;
   localparam logic [4:0] S_BIND    = 5'd12;
   localparam logic [4:0] S_OPA     = 5'd13;
   localparam logic [4:0] S_OPA_W   = 5'd14;
   localparam logic [4:0] S_OPB     = 5'd15;
   localparam logic [4:0] S_OPB_W   = 5'd16;
   localparam logic [4:0] S_EXEC    = 5'd17;
   localparam logic [4:0] S_PUSH    = 5'd18;
   localparam logic [4:0] S_PUSH2   = 5'd19;
   localparam logic [4:0] S_REFRESH = 5'd20;
   localparam logic [4:0] S_NEXT    = 5'd21;
   localparam logic [4:0] S_TEND    = 5'd22;
   localparam logic [4:0] S_FCHK    = 5'd23;
   localparam logic [4:0] S_FRD     = 5'd24;
   localparam logic [4:0] S_DONE    = 5'd25;

   localparam logic [1:0] TGT_A     = 2'd0;
   localparam logic [1:0] TGT_NXT   = 2'd1;
   localparam logic [1:0] TGT_NXT2  = 2'd2;
   localparam logic [1:0] TGT_FAULT = 2'd3;

   localparam logic [15:0] MAX_TURNS_RESET = 16'd1000;

   logic [4:0]          state_ff, state_in;
   logic [CORE_AW-1:0]  addr_ff, addr_in;
   logic [WORD_W-1:0]   data_ff, data_in;
   logic                player_ff, player_in;
   logic [CORE_AW-1:0]  pc_ff, pc_in, mid_ff, mid_in;
   logic [CORE_AW-1:0]  aaddr_ff, aaddr_in, baddr_ff, baddr_in;
   logic [WORD_W-1:0]   w_ff, w_in, aval_ff, aval_in, bval_ff, bval_in;
   logic                atemp_ff, atemp_in, btemp_ff, btemp_in;
   logic [1:0]          tgt_ff, tgt_in;
   logic                spl2_ff, spl2_in;
   logic                ok1_ff, ok1_in, ok2_ff, ok2_in;
   logic [CORE_AW-1:0]  scan_ff, scan_in;
   logic                found1_ff, found1_in, found2_ff, found2_in;
   logic [CORE_AW-1:0]  start1_ff, start1_in, start2_ff, start2_in;
   logic [CELL_W-1:0]   owned1_ff, owned1_in, owned2_ff, owned2_in;
   logic [15:0]         turns_ff, turns_in, max_turns_ff, max_turns_in;
   logic [1:0]          result_ff, result_in;
   logic                ovf_ff, ovf_in;
   logic [WORD_W-1:0]   rd_ff, rd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          o_outcome_ff, o_outcome_in;
   logic [15:0]         o_turns_ff, o_turns_in;
   logic [10:0]         o_cells1_ff, o_cells1_in, o_cells2_ff, o_cells2_in;
   logic [31:0]         o_rd_ff, o_rd_in;
   logic [9:0]          o_pc1_ff, o_pc1_in, o_pc2_ff, o_pc2_in;
   logic [6:0]          o_cnt1_ff, o_cnt1_in, o_cnt2_ff, o_cnt2_in;
   logic                o_ovf_ff, o_ovf_in;

   logic                core_we, core_ren;
   logic [CORE_AW-1:0]  core_waddr, core_raddr;
   logic [WORD_W-1:0]   core_wdata, core_rdata;
   logic                st_en;
   logic [1:0]          st_old;
   logic [FIELD_W-1:0]  alu_a, alu_b, alu_sum;
   logic                alu_sub;
   redc_qctl_type       cur_ctl, q1_ctl, q2_ctl;
   redc_qstat_type      q1_stat, q2_stat, cur_stat;
   logic [1:0]          tag;
   logic [WORD_W-1:0]   bnew;
   logic [CORE_AW-1:0]  tgt_addr;
   logic [15:0]         turns_inc;

   redc_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .sum(alu_sum));

   redc_core u_core (
      .clock(clock), .we(core_we), .waddr(core_waddr), .wdata(core_wdata),
      .ren(core_ren), .raddr(core_raddr), .rdata(core_rdata));

   redc_queue u_q1 (.clock(clock), .reset(reset), .ctl(q1_ctl), .stat(q1_stat));
   redc_queue u_q2 (.clock(clock), .reset(reset), .ctl(q2_ctl), .stat(q2_stat));

   assign tag       = player_ff ? OWNER_SECOND : OWNER_FIRST;
   assign cur_stat  = player_ff ? q2_stat : q1_stat;
   assign turns_inc = turns_ff + 16'd1;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff; addr_in = addr_ff; data_in = data_ff;
      player_in = player_ff; pc_in = pc_ff; mid_in = mid_ff;
      aaddr_in = aaddr_ff; baddr_in = baddr_ff; w_in = w_ff;
      aval_in = aval_ff; bval_in = bval_ff; atemp_in = atemp_ff; btemp_in = btemp_ff;
      tgt_in = tgt_ff; spl2_in = spl2_ff; ok1_in = ok1_ff; ok2_in = ok2_ff;
      scan_in = scan_ff; found1_in = found1_ff; found2_in = found2_ff;
      start1_in = start1_ff; start2_in = start2_ff;
      turns_in = turns_ff; result_in = result_ff; ovf_in = ovf_ff; rd_in = rd_ff;
      max_turns_in = csr_we ? csr_wdata : max_turns_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_outcome_in = o_outcome_ff; o_turns_in = o_turns_ff;
      o_cells1_in = o_cells1_ff; o_cells2_in = o_cells2_ff; o_rd_in = o_rd_ff;
      o_pc1_in = o_pc1_ff; o_pc2_in = o_pc2_ff; o_cnt1_in = o_cnt1_ff;
      o_cnt2_in = o_cnt2_ff; o_ovf_in = o_ovf_ff;
      core_we = 1'b0; core_waddr = pc_ff; core_wdata = '0;
      core_ren = 1'b0; core_raddr = pc_ff;
      st_en = 1'b0; st_old = core_rdata[31:30];
      alu_a = pc_ff; alu_b = '0; alu_sub = 1'b0;
      cur_ctl = '0; q1_ctl = '0; q2_ctl = '0;
      bnew = '0; tgt_addr = aaddr_ff;

      case (state_ff)
         S_CLEAR: begin
            core_we = 1'b1;
            core_waddr = scan_ff;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == CORE_AW'(CORE_SIZE - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               addr_in = req_address;
               data_in = req_data;
               rd_in = '0;
               case (req_cmd)
                  CMD_LOAD: begin
                     core_ren = 1'b1;
                     core_raddr = req_address;
                     state_in = S_LD_WR;
                  end
                  CMD_START: begin
                     scan_in = '0;
                     found1_in = 1'b0;
                     found2_in = 1'b0;
                     state_in = S_SCAN_RD;
                  end
                  CMD_TURN: begin
                     player_in = 1'b0;
                     if (result_ff == RES_RUNNING && q1_stat.count != '0 &&
                         q2_stat.count != '0) state_in = S_CHK;
                     else state_in = S_DONE;
                  end
                  default: begin
                     core_ren = 1'b1;
                     core_raddr = req_address;
                     state_in = S_RD_DAT;
                  end
               endcase
            end
         end
         S_LD_WR: begin
            core_we = 1'b1;
            core_waddr = addr_ff;
            core_wdata = data_ff;
            st_en = 1'b1;
            state_in = S_DONE;
         end
         S_RD_DAT: begin
            rd_in = core_rdata;
            state_in = S_DONE;
         end
         S_SCAN_RD: begin
            core_ren = 1'b1;
            core_raddr = scan_ff;
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (!found1_ff && core_rdata[30] && core_rdata[29:26] != OP_DAT) begin
               found1_in = 1'b1;
               start1_in = scan_ff;
            end
            if (!found2_ff && core_rdata[31] && core_rdata[29:26] != OP_DAT) begin
               found2_in = 1'b1;
               start2_in = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
            state_in = (scan_ff == CORE_AW'(CORE_SIZE - 1)) ? S_START : S_SCAN_RD;
         end
         S_START: begin
            q1_ctl.init = 1'b1;
            q1_ctl.wdata = found1_ff ? {1'b0, start1_ff} : {1'b1, CORE_AW'(0)};
            q2_ctl.init = 1'b1;
            q2_ctl.wdata = found2_ff ? {1'b0, start2_ff} : {1'b1, CORE_AW'(0)};
            turns_in = '0;
            result_in = RES_RUNNING;
            ovf_in = 1'b0;
            state_in = S_DONE;
         end
         S_CHK: begin
            if (cur_stat.count == '0 || cur_stat.front[CORE_AW]) begin
               if (player_ff) ok2_in = 1'b0; else ok1_in = 1'b0;
               state_in = S_NEXT;
            end else begin
               core_ren = 1'b1;
               core_raddr = cur_stat.front[CORE_AW-1:0];
               pc_in = cur_stat.front[CORE_AW-1:0];
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (core_rdata[29:26] == OP_DAT) begin
               if (player_ff) ok2_in = 1'b0; else ok1_in = 1'b0;
               state_in = S_NEXT;
            end else begin
               if (player_ff) ok2_in = 1'b1; else ok1_in = 1'b1;
               cur_ctl.pop = 1'b1;
               w_in = {tag, core_rdata[29:0]};
               core_we = 1'b1;
               core_wdata = {tag, core_rdata[29:0]};
               st_en = 1'b1;
               spl2_in = 1'b0;
               state_in = S_ARES;
            end
         end
         S_ARES: begin
            alu_b = w_ff[22:13];
            atemp_in = 1'b0;
            case (w_ff[24:23])
               MODE_IMM: begin
                  atemp_in = 1'b1;
                  aval_in = {tag, 20'd0, w_ff[22:13]};
                  aaddr_in = pc_ff;
                  state_in = S_BRES;
               end
               MODE_REL: begin
                  aaddr_in = alu_sum;
                  state_in = S_BRES;
               end
               MODE_IND: begin
                  mid_in = alu_sum;
                  core_ren = 1'b1;
                  core_raddr = alu_sum;
                  state_in = S_AIND;
               end
               default: begin
                  tgt_in = TGT_FAULT;
                  state_in = S_PUSH;
               end
            endcase
         end
         S_AIND: begin
            alu_a = mid_ff;
            alu_b = core_rdata[9:0];
            aaddr_in = alu_sum;
            state_in = S_BRES;
         end
         S_BRES: begin
            alu_b = w_ff[9:0];
            btemp_in = 1'b0;
            case (w_ff[11:10])
               MODE_IMM: begin
                  btemp_in = 1'b1;
                  bval_in = {tag, 20'd0, w_ff[9:0]};
                  baddr_in = pc_ff;
                  state_in = S_OPA;
               end
               MODE_REL: begin
                  baddr_in = alu_sum;
                  state_in = S_OPA;
               end
               MODE_IND: begin
                  mid_in = alu_sum;
                  core_ren = 1'b1;
                  core_raddr = alu_sum;
                  state_in = S_BIND;
               end
               default: begin
                  tgt_in = TGT_FAULT;
                  state_in = S_PUSH;
               end
            endcase
         end
         S_BIND: begin
            alu_a = mid_ff;
            alu_b = core_rdata[9:0];
            baddr_in = alu_sum;
            state_in = S_OPA;
         end
         S_OPA: begin
            if (atemp_ff) state_in = S_OPB;
            else begin
               core_ren = 1'b1;
               core_raddr = aaddr_ff;
               state_in = S_OPA_W;
            end
         end
         S_OPA_W: begin
            aval_in = core_rdata;
            state_in = S_OPB;
         end
         S_OPB: begin
            if (btemp_ff) state_in = S_EXEC;
            else begin
               core_ren = 1'b1;
               core_raddr = baddr_ff;
               state_in = S_OPB_W;
            end
         end
         S_OPB_W: begin
            bval_in = core_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // The B operand's old word is in bval, so a core store here can
            // update the ownership counters without another read.
            alu_a = bval_ff[9:0];
            alu_b = aval_ff[9:0];
            core_waddr = baddr_ff;
            st_old = bval_ff[31:30];
            bnew = {bval_ff[31:10], alu_sum};
            tgt_in = TGT_NXT;
            state_in = S_PUSH;
            case (w_ff[29:26])
               OP_MOV: begin
                  core_we = !btemp_ff;
                  st_en = !btemp_ff;
                  core_wdata = aval_ff;
               end
               OP_ADD: begin
                  core_we = !btemp_ff;
                  st_en = !btemp_ff;
                  core_wdata = bnew;
               end
               OP_SUB: begin
                  alu_sub = 1'b1;
                  core_we = !btemp_ff;
                  st_en = !btemp_ff;
                  core_wdata = bnew;
               end
               OP_JMP: tgt_in = TGT_A;
               OP_JMZ: tgt_in = (bval_ff[9:0] == '0) ? TGT_A : TGT_NXT;
               OP_JMN: tgt_in = (bval_ff[9:0] != '0) ? TGT_A : TGT_NXT;
               OP_DJN: begin
                  alu_b = FIELD_W'(1);
                  alu_sub = 1'b1;
                  core_we = !btemp_ff;
                  st_en = !btemp_ff;
                  core_wdata = bnew;
                  tgt_in = (alu_sum != '0) ? TGT_A : TGT_NXT;
               end
               OP_CMP: tgt_in = (aval_ff != bval_ff) ? TGT_NXT2 : TGT_NXT;
               OP_SPL: begin
                  tgt_in = TGT_A;
                  spl2_in = 1'b1;
               end
               default: tgt_in = TGT_FAULT;
            endcase
         end
         S_PUSH: begin
            alu_b = (tgt_ff == TGT_NXT2) ? FIELD_W'(2) : FIELD_W'(1);
            case (tgt_ff)
               TGT_A:    tgt_addr = aaddr_ff;
               TGT_NXT:  tgt_addr = alu_sum;
               TGT_NXT2: tgt_addr = alu_sum;
               default:  tgt_addr = pc_ff;
            endcase
            cur_ctl.push = 1'b1;
            cur_ctl.wdata = {(tgt_ff == TGT_FAULT), tgt_addr};
            if (cur_stat.full) ovf_in = 1'b1;
            spl2_in = 1'b0;
            state_in = spl2_ff ? S_PUSH2 : S_REFRESH;
         end
         S_PUSH2: begin
            alu_b = FIELD_W'(1);
            cur_ctl.push = 1'b1;
            cur_ctl.wdata = {1'b0, alu_sum};
            if (cur_stat.full) ovf_in = 1'b1;
            state_in = S_REFRESH;
         end
         S_REFRESH: begin
            cur_ctl.refresh = 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (!player_ff) begin
               player_in = 1'b1;
               state_in = S_CHK;
            end else begin
               state_in = S_TEND;
            end
         end
         S_TEND: begin
            turns_in = turns_inc;
            state_in = S_DONE;
            if (turns_inc >= max_turns_ff) result_in = RES_TIE;
            else if (!ok1_ff) result_in = RES_SECOND;
            else if (!ok2_ff) state_in = S_FCHK;
         end
         S_FCHK: begin
            if (q1_stat.count == '0 || q1_stat.front[CORE_AW]) begin
               result_in = RES_SECOND;
               state_in = S_DONE;
            end else begin
               core_ren = 1'b1;
               core_raddr = q1_stat.front[CORE_AW-1:0];
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            result_in = (core_rdata[29:26] != OP_DAT) ? RES_FIRST : RES_SECOND;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_outcome_in = result_ff;
               o_turns_in = turns_ff;
               o_cells1_in = owned1_ff;
               o_cells2_in = owned2_ff;
               o_rd_in = rd_ff;
               o_pc1_in = (q1_stat.count != '0) ? q1_stat.front[CORE_AW-1:0] : '0;
               o_pc2_in = (q2_stat.count != '0) ? q2_stat.front[CORE_AW-1:0] : '0;
               o_cnt1_in = q1_stat.count;
               o_cnt2_in = q2_stat.count;
               o_ovf_in = ovf_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (player_ff) q2_ctl = q2_ctl | cur_ctl;
      else q1_ctl = q1_ctl | cur_ctl;
   end

   always_comb begin
      owned1_in = owned1_ff;
      owned2_in = owned2_ff;
      if (st_en) begin
         owned1_in = cell_count_next(owned1_ff, st_old, core_wdata[31:30], OWNER_FIRST);
         owned2_in = cell_count_next(owned2_ff, st_old, core_wdata[31:30], OWNER_SECOND);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         scan_ff <= '0;
         owned1_ff <= '0;
         owned2_ff <= '0;
         turns_ff <= '0;
         result_ff <= RES_RUNNING;
         ovf_ff <= 1'b0;
         max_turns_ff <= MAX_TURNS_RESET;
         rsp_valid_ff <= 1'b0;
         spl2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff <= scan_in;
         owned1_ff <= owned1_in;
         owned2_ff <= owned2_in;
         turns_ff <= turns_in;
         result_ff <= result_in;
         ovf_ff <= ovf_in;
         max_turns_ff <= max_turns_in;
         rsp_valid_ff <= rsp_valid_in;
         spl2_ff <= spl2_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in; data_ff <= data_in;
      player_ff <= player_in; pc_ff <= pc_in; mid_ff <= mid_in;
      aaddr_ff <= aaddr_in; baddr_ff <= baddr_in; w_ff <= w_in;
      aval_ff <= aval_in; bval_ff <= bval_in; atemp_ff <= atemp_in;
      btemp_ff <= btemp_in; tgt_ff <= tgt_in; ok1_ff <= ok1_in; ok2_ff <= ok2_in;
      found1_ff <= found1_in; found2_ff <= found2_in;
      start1_ff <= start1_in; start2_ff <= start2_in; rd_ff <= rd_in;
      o_outcome_ff <= o_outcome_in; o_turns_ff <= o_turns_in;
      o_cells1_ff <= o_cells1_in; o_cells2_ff <= o_cells2_in; o_rd_ff <= o_rd_in;
      o_pc1_ff <= o_pc1_in; o_pc2_ff <= o_pc2_in;
      o_cnt1_ff <= o_cnt1_in; o_cnt2_ff <= o_cnt2_in; o_ovf_ff <= o_ovf_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_outcome = o_outcome_ff;
   assign rsp_turn_count = o_turns_ff;
   assign rsp_first_cells = o_cells1_ff;
   assign rsp_second_cells = o_cells2_ff;
   assign rsp_read_data = o_rd_ff;
   assign rsp_first_front_pc = o_pc1_ff;
   assign rsp_second_front_pc = o_pc2_ff;
   assign rsp_first_processes = o_cnt1_ff;
   assign rsp_second_processes = o_cnt2_ff;
   assign rsp_split_overflow = o_ovf_ff;
endmodule

>>> rtl/redcode_battle_executor.sv
// Top level of the two-player Redcode battle executor.
// Depends on redc_pkg and redc_sequencer (which holds the core, queues and adder).
//
// This block runs a two-player Redcode battle in a 1024-word core held in a
// memory with one write port and one registered read port. Each request
// transfer carries one command (load a word, start the battle, run one turn,
// read a word) and produces exactly one response transfer holding the battle
// status and, for a read, the core word. After reset the block sweeps the
// core to zero, one word per cycle, and takes no request until the sweep is
// done; the max_turns register can be written at any time through
// csr_we/csr_wdata. All timing is set by the core memory and the shared
// 10-bit adder that a small sequencer drives: a load reads the old word and
// then writes the new one, a read fetches the word, a start scans every core
// word with a read and a compare, and a turn is shortest when it is ignored
// (before a start or after the end), short when neither player can run, and
// longest with two indirect operands per player and a split with two queue
// pushes. A finished response sits in an output register, so the sender sees
// ready again as soon as that register is free or being taken.
module redcode_battle_executor import redc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_address,
   input  logic [31:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_outcome,
   output logic [15:0] rsp_turn_count,
   output logic [10:0] rsp_first_cells,
   output logic [10:0] rsp_second_cells,
   output logic [31:0] rsp_read_data,
   output logic [9:0]  rsp_first_front_pc,
   output logic [9:0]  rsp_second_front_pc,
   output logic [6:0]  rsp_first_processes,
   output logic [6:0]  rsp_second_processes,
   output logic        rsp_split_overflow,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   // The sequencer owns every stored element; this level only names the ports.
   redc_sequencer u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_address(req_address), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_outcome(rsp_outcome), .rsp_turn_count(rsp_turn_count),
      .rsp_first_cells(rsp_first_cells), .rsp_second_cells(rsp_second_cells),
      .rsp_read_data(rsp_read_data),
      .rsp_first_front_pc(rsp_first_front_pc),
      .rsp_second_front_pc(rsp_second_front_pc),
      .rsp_first_processes(rsp_first_processes),
      .rsp_second_processes(rsp_second_processes),
      .rsp_split_overflow(rsp_split_overflow),
      .csr_we(csr_we), .csr_wdata(csr_wdata));
endmodule

>>> tb/sv/redcode_battle_checker.sv
// Checker for the Redcode battle executor: watches both channels and the csr port,
// predicts every response and compares it field by field. Depends on redc_pkg.
module redcode_battle_checker import redc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_address,
   input  logic [31:0] req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_outcome,
   input  logic [15:0] rsp_turn_count,
   input  logic [10:0] rsp_first_cells,
   input  logic [10:0] rsp_second_cells,
   input  logic [31:0] rsp_read_data,
   input  logic [9:0]  rsp_first_front_pc,
   input  logic [9:0]  rsp_second_front_pc,
   input  logic [6:0]  rsp_first_processes,
   input  logic [6:0]  rsp_second_processes,
   input  logic        rsp_split_overflow,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [15:0] turns;
      logic [10:0] cells1;
      logic [10:0] cells2;
      logic [31:0] rdata;
      logic [9:0]  pc1;
      logic [9:0]  pc2;
      logic [6:0]  procs1;
      logic [6:0]  procs2;
      logic        ovf;
   } status_t;

   typedef struct {
      logic [9:0]  addr;
      bit          temp;
      logic [31:0] tval;
   } operand_t;

   logic [31:0] core [CORE_SIZE];
   logic [10:0] procq [2][QUEUE_DEPTH];
   logic [5:0]  qhead [2];
   logic [6:0]  qcount [2];
   logic [15:0] turns_done, turn_limit;
   logic [10:0] cells [2];
   logic [1:0]  result;
   bit          split_lost;
   status_t     expected_status [$];

   function automatic void store_word(logic [9:0] a, logic [31:0] v);
      if (core[a][31:30] == OWNER_FIRST)  cells[0]--;
      if (core[a][31:30] == OWNER_SECOND) cells[1]--;
      if (v[31:30] == OWNER_FIRST)  cells[0]++;
      if (v[31:30] == OWNER_SECOND) cells[1]++;
      core[a] = v;
   endfunction

   function automatic logic [31:0] operand_word(operand_t o);
      return o.temp ? o.tval : core[o.addr];
   endfunction

   function automatic void operand_store(inout operand_t o, input logic [31:0] v);
      if (o.temp) o.tval = v;
      else store_word(o.addr, v);
   endfunction

   function automatic void push_process(int p, logic [10:0] e);
      if (qcount[p] < QUEUE_DEPTH) begin
         procq[p][qhead[p] + qcount[p][5:0]] = e;
         qcount[p]++;
      end else begin
         split_lost = 1'b1;
      end
   endfunction

   function automatic bit can_run(int p);
      logic [10:0] e;
      if (qcount[p] == 0) return 1'b0;
      e = procq[p][qhead[p]];
      if (e[10]) return 1'b0;
      return core[e[9:0]][29:26] != OP_DAT;
   endfunction

   // Offsets are 10-bit two's complement, so plain 10-bit addition wraps the core.
   function automatic bit resolve(logic [9:0] pc, logic [1:0] mode, logic [9:0] field,
                                  logic [1:0] owner, output operand_t o);
      logic [9:0] mid;
      o.temp = 1'b0;
      o.tval = '0;
      o.addr = pc;
      case (mode)
         MODE_IMM: begin
            o.temp = 1'b1;
            o.tval = {owner, 20'd0, field};
         end
         MODE_REL: o.addr = pc + field;
         MODE_IND: begin
            mid = pc + field;
            o.addr = mid + core[mid][9:0];
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic void run_process(int p);
      logic [9:0]  pc;
      logic [31:0] w;
      logic [3:0]  op;
      logic [9:0]  x, y;
      logic [1:0]  owner;
      logic [31:0] aw, bw;
      operand_t    a, b;
      owner = (p == 0) ? OWNER_FIRST : OWNER_SECOND;
      pc = procq[p][qhead[p]][9:0];
      qhead[p]++;
      qcount[p]--;
      w = core[pc];
      op = w[29:26];
      store_word(pc, {owner, w[29:0]});
      w = core[pc];
      if (!resolve(pc, w[24:23], w[22:13], owner, a) ||
          !resolve(pc, w[11:10], w[9:0], owner, b)) begin
         push_process(p, {1'b1, pc});
         return;
      end
      case (op)
         OP_MOV: begin
            operand_store(b, operand_word(a));
            push_process(p, {1'b0, pc + 10'd1});
         end
         OP_ADD, OP_SUB: begin
            bw = operand_word(b);
            aw = operand_word(a);
            y = bw[9:0];
            x = aw[9:0];
            operand_store(b, {bw[31:10], (op == OP_ADD) ? y + x : y - x});
            push_process(p, {1'b0, pc + 10'd1});
         end
         OP_JMP: push_process(p, {1'b0, a.addr});
         OP_JMZ: begin
            bw = operand_word(b);
            push_process(p, {1'b0, (bw[9:0] == 0) ? a.addr : pc + 10'd1});
         end
         OP_JMN: begin
            bw = operand_word(b);
            push_process(p, {1'b0, (bw[9:0] != 0) ? a.addr : pc + 10'd1});
         end
         OP_DJN: begin
            bw = operand_word(b);
            y = bw[9:0];
            operand_store(b, {bw[31:10], y - 10'd1});
            bw = operand_word(b);
            push_process(p, {1'b0, (bw[9:0] != 0) ? a.addr : pc + 10'd1});
         end
         OP_CMP: push_process(p, {1'b0, (operand_word(b) != operand_word(a)) ?
                                        pc + 10'd2 : pc + 10'd1});
         OP_SPL: begin
            push_process(p, {1'b0, a.addr});
            push_process(p, {1'b0, pc + 10'd1});
         end
         default: push_process(p, {1'b1, pc});
      endcase
   endfunction

   function automatic logic [10:0] first_owned(logic [1:0] owner);
      for (int i = 0; i < CORE_SIZE; i++)
         if ((core[i][31:30] & owner) != 0 && core[i][29:26] != OP_DAT)
            return {1'b0, i[9:0]};
      return 11'h400;
   endfunction

   function automatic status_t battle_step(logic [1:0] cmd, logic [9:0] addr,
                                           logic [31:0] data);
      status_t s;
      bit ok1, ok2;
      s.rdata = '0;
      case (cmd)
         CMD_LOAD: store_word(addr, data);
         CMD_START: begin
            qhead = '{6'd0, 6'd0};
            procq[0][0] = first_owned(OWNER_FIRST);
            procq[1][0] = first_owned(OWNER_SECOND);
            qcount = '{7'd1, 7'd1};
            turns_done = '0;
            result = RES_RUNNING;
            split_lost = 1'b0;
         end
         CMD_TURN: begin
            if (result == RES_RUNNING && qcount[0] != 0 && qcount[1] != 0) begin
               ok1 = can_run(0);
               if (ok1) run_process(0);
               ok2 = can_run(1);
               if (ok2) run_process(1);
               turns_done++;
               if (turns_done >= turn_limit) result = RES_TIE;
               else if (!ok1 || !ok2)
                  result = (ok1 && can_run(0)) ? RES_FIRST : RES_SECOND;
            end
         end
         default: s.rdata = core[addr];
      endcase
      s.outcome = result;
      s.turns   = turns_done;
      s.cells1  = cells[0];
      s.cells2  = cells[1];
      s.pc1     = qcount[0] != 0 ? procq[0][qhead[0]][9:0] : 10'd0;
      s.pc2     = qcount[1] != 0 ? procq[1][qhead[1]][9:0] : 10'd0;
      s.procs1  = qcount[0];
      s.procs2  = qcount[1];
      s.ovf     = split_lost;
      return s;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      foreach (core[i]) core[i] = '0;
      qhead = '{6'd0, 6'd0};
      qcount = '{7'd0, 7'd0};
      cells = '{11'd0, 11'd0};
      turns_done = '0;
      turn_limit = 16'd1000;
      result = RES_RUNNING;
      split_lost = 1'b0;
   end

   always @(posedge clock) begin
      status_t want;
      if (!reset) begin
         if (csr_we) turn_limit = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $display("%0t: response transfer with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_outcome != want.outcome)
                  report("outcome", 32'(rsp_outcome), 32'(want.outcome));
               if (rsp_turn_count != want.turns)
                  report("turn_count", 32'(rsp_turn_count), 32'(want.turns));
               if (rsp_first_cells != want.cells1)
                  report("first_cells", 32'(rsp_first_cells), 32'(want.cells1));
               if (rsp_second_cells != want.cells2)
                  report("second_cells", 32'(rsp_second_cells), 32'(want.cells2));
               if (rsp_read_data != want.rdata)
                  report("read_data", rsp_read_data, want.rdata);
               if (rsp_first_front_pc != want.pc1)
                  report("first_front_pc", 32'(rsp_first_front_pc), 32'(want.pc1));
               if (rsp_second_front_pc != want.pc2)
                  report("second_front_pc", 32'(rsp_second_front_pc), 32'(want.pc2));
               if (rsp_first_processes != want.procs1)
                  report("first_processes", 32'(rsp_first_processes), 32'(want.procs1));
               if (rsp_second_processes != want.procs2)
                  report("second_processes", 32'(rsp_second_processes),
                         32'(want.procs2));
               if (rsp_split_overflow != want.ovf)
                  report("split_overflow", 32'(rsp_split_overflow), 32'(want.ovf));
            end
         end
         if (req_valid && req_ready)
            expected_status.push_back(battle_step(req_cmd, req_address, req_data));
      end
      pending = expected_status.size();
   end

endmodule

>>> tb/sv/tb_redcode_battle_executor.sv
// Top of the Redcode battle executor testbench: clock, reset, stimulus and verdict.
// Depends on redc_pkg, redcode_battle_executor and redcode_battle_checker.
module tb_redcode_battle_executor;
   import redc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // No transfer for this many cycles means the block has hung. The slowest
   // legal gap is the clearing sweep after reset or a start scan plus a
   // receiver stall, so this leaves a wide margin.
   localparam int STALL_LIMIT = 20000;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_cmd;
   logic [9:0]  req_address;
   logic [31:0] req_data;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_outcome;
   logic [15:0] rsp_turn_count;
   logic [10:0] rsp_first_cells, rsp_second_cells;
   logic [31:0] rsp_read_data;
   logic [9:0]  rsp_first_front_pc, rsp_second_front_pc;
   logic [6:0]  rsp_first_processes, rsp_second_processes;
   logic        rsp_split_overflow;
   logic        csr_we;
   logic [15:0] csr_wdata;
   int          fail_count, pending;
   int          items_sent;
   int          burst_left;
   int          quiet_cycles;

   redcode_battle_executor u_top (.*);

   redcode_battle_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL redcode_battle_executor");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver picks a new behaviour whenever its tick counter wraps: always
   // ready, sometimes dropping ready at random, sometimes holding off for
   // long stretches so that responses back up into the output register.
   int rx_mode, rx_tick;
   always @(negedge clock) begin
      if (rx_tick == 0) rx_mode <= $urandom_range(0, 2);
      rx_tick <= (rx_tick + 1) % 64;
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // One request transfer. Between most bursts the sender lowers valid for a random
   // gap; within a burst valid stays high from one transfer into the next.
   task automatic send(logic [1:0] cmd, logic [9:0] addr, logic [31:0] data);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 20)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_address <= addr;
      req_data    <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // The register is only written once every response is home and the
   // request line is quiet.
   task automatic set_turn_limit(logic [15:0] limit);
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= limit;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= 16'($urandom());
   endtask

   // A plausible instruction: valid modes and opcodes with short offsets, and
   // now and then an invalid mode or opcode so that faults occur.
   function automatic logic [31:0] instruction(logic [1:0] owner);
      logic [3:0] op;
      logic [1:0] ma, mb;
      logic [9:0] af, bf;
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(1, 9));
      if ($urandom_range(0, 9) == 0) op = OP_DAT;
      ma = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      mb = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      af = 10'($urandom_range(0, 16) - 8);
      bf = 10'($urandom_range(0, 16) - 8);
      return {owner, op, 1'($urandom()), ma, af, 1'($urandom()), mb, bf};
   endfunction

   function automatic logic [31:0] word_of(logic [1:0] owner, logic [3:0] op,
                                           logic [1:0] ma, logic [9:0] af,
                                           logic [1:0] mb, logic [9:0] bf);
      return {owner, op, 1'b0, ma, af, 1'b0, mb, bf};
   endfunction

   // Places a short warrior for each player at random spots and lets the battle begin.
   task automatic place_warriors();
      logic [9:0] base1, base2;
      base1 = 10'($urandom());
      base2 = base1 + 10'd300 + 10'($urandom_range(0, 400));
      for (int i = 0; i < $urandom_range(2, 5); i++) begin
         send(CMD_LOAD, base1 + i[9:0], instruction(OWNER_FIRST));
         send(CMD_LOAD, base2 + i[9:0], instruction(OWNER_SECOND));
      end
      send(CMD_START, 10'($urandom()), $urandom());
   endtask

   task automatic random_battle_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 72)      send(CMD_TURN, 10'($urandom()), $urandom());
      else if (pick < 84) send(CMD_READ, 10'($urandom()), $urandom());
      else if (pick < 94) send(CMD_LOAD, 10'($urandom()),
                               instruction(2'($urandom_range(0, 3))));
      else if (pick < 97) send(CMD_LOAD, 10'($urandom()), $urandom());
      else                send(CMD_START, 10'($urandom()), $urandom());
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_LOAD;
      req_address = '0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      rx_mode     = 0;
      rx_tick     = 0;
      items_sent  = 0;
      burst_left  = 0;
      quiet_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A turn before any start is ignored; extreme addresses
      // and words round-trip; a start on a core with no live code faults both
      // players, so the next turn ends the game in favour of player two.
      send(CMD_TURN, 10'd0, 32'd0);
      send(CMD_LOAD, 10'd0, 32'hffff_ffff);
      send(CMD_LOAD, 10'd1023, 32'h0000_0000);
      send(CMD_READ, 10'd0, 32'd0);
      send(CMD_READ, 10'd1023, 32'hffff_ffff);
      send(CMD_LOAD, 10'd0, 32'd0);
      send(CMD_START, 10'd0, 32'd0);
      send(CMD_TURN, 10'd0, 32'd0);
      send(CMD_TURN, 10'd0, 32'd0);

      // A limit of one turn ends the battle as a tie at once: a shared-owner
      // word is found by both scans, so both players start on the same imp.
      set_turn_limit(16'd1);
      send(CMD_LOAD, 10'd10, word_of(2'd3, OP_MOV, MODE_REL, 10'd0, MODE_REL, 10'd1));
      send(CMD_START, 10'd0, 32'd0);
      send(CMD_TURN, 10'd0, 32'd0);
      send(CMD_TURN, 10'd0, 32'd0);

      // Words of every opcode but DAT, with immediate, relative and indirect
      // operands, and finally an invalid opcode and mode.
      set_turn_limit(16'hffff);
      send(CMD_LOAD, 10'd10, 32'd0);
      send(CMD_LOAD, 10'd40, word_of(OWNER_FIRST, OP_ADD, MODE_IMM, 10'd5, MODE_IND, 10'd3));
      send(CMD_LOAD, 10'd41, word_of(OWNER_FIRST, OP_SUB, MODE_REL, 10'h3ff, MODE_IMM, 10'd1));
      send(CMD_LOAD, 10'd42, word_of(OWNER_FIRST, OP_DJN, MODE_REL, 10'd0, MODE_IMM, 10'd2));
      send(CMD_LOAD, 10'd43, word_of(OWNER_FIRST, OP_CMP, MODE_IMM, 10'd0, MODE_REL, 10'd0));
      send(CMD_LOAD, 10'd45, word_of(OWNER_FIRST, OP_JMZ, MODE_REL, 10'd2, MODE_REL, 10'd1));
      send(CMD_LOAD, 10'd47, word_of(OWNER_FIRST, OP_JMN, MODE_REL, 10'h3fb, MODE_IND, 10'd0));
      send(CMD_LOAD, 10'd48, word_of(OWNER_FIRST, 4'd12, MODE_REL, 10'd0, 2'd3, 10'd0));
      send(CMD_LOAD, 10'd600, word_of(OWNER_SECOND, OP_SPL, MODE_REL, 10'd2, MODE_REL, 10'd0));
      send(CMD_LOAD, 10'd601, word_of(OWNER_SECOND, OP_JMP, MODE_REL, 10'h3ff, MODE_IMM, 10'd0));
      send(CMD_LOAD, 10'd602, word_of(OWNER_SECOND, OP_MOV, MODE_REL, 10'd0, MODE_REL, 10'd1));
      send(CMD_START, 10'd0, 32'd0);
      repeat (10) send(CMD_TURN, 10'd0, 32'd0);

      // A split bomb fills player one's queue until pushes are dropped,
      // against the player-two split-and-imp warrior left from the last test.
      set_turn_limit(16'd1000);
      for (int i = 0; i < 50; i++) send(CMD_LOAD, 10'(i), 32'd0);
      send(CMD_LOAD, 10'd100, word_of(OWNER_FIRST, OP_SPL, MODE_REL, 10'd0, MODE_IMM, 10'd0));
      send(CMD_LOAD, 10'd101, word_of(OWNER_FIRST, OP_JMP, MODE_REL, 10'h3ff, MODE_IMM, 10'd0));
      send(CMD_START, 10'd0, 32'd0);
      repeat (140) send(CMD_TURN, 10'd0, 32'd0);

      // Random battles, each with its own turn limit.
      while (items_sent < 520) begin
         case ($urandom_range(0, 3))
            0: set_turn_limit(16'($urandom_range(2, 12)));
            1: set_turn_limit(16'hffff);
            default: set_turn_limit(16'($urandom_range(1, 65535)));
         endcase
         place_warriors();
         repeat ($urandom_range(30, 70)) random_battle_item();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS redcode_battle_executor");
      end else begin
         $display("FAIL redcode_battle_executor");
      end
      $finish;
   end

endmodule
